// ===== hdl/packet_flow_key_extractor_defines.svh =====
// Assertion macros shared by the flow key extractor RTL.
// No dependencies; included by the files that carry concurrent checks.
`ifndef PACKET_FLOW_KEY_EXTRACTOR_DEFINES_SVH
`define PACKET_FLOW_KEY_EXTRACTOR_DEFINES_SVH

`ifndef SYNTHESIS
// Check a property on every rising edge outside reset.
`define PFKE_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Check that a condition leads to a consequence on the next edge.
`define PFKE_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define PFKE_ASSERT(lbl, clk, rstn, prop, msg)
`define PFKE_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

// ===== hdl/pfke_pkg.sv =====
// Types and constants of the packet flow key extractor.
// No dependencies; imported by pfke_field_capture, the top level and the bench.
package pfke_pkg;

  localparam logic [15:0] EthTypeTag = 16'h8100;
  localparam logic [15:0] EthTypeIp4 = 16'h0800;
  localparam logic [11:0] VidMask    = 12'hFFF;
  localparam int unsigned PcpShift   = 13;

  localparam logic [7:0] IpProtoTcp = 8'd6;
  localparam logic [7:0] IpProtoUdp = 8'd17;

  // Byte offsets from the start of the frame.
  localparam logic [5:0] OffMacSrc    = 6'd6;
  localparam logic [5:0] OffEtype     = 6'd12;
  localparam logic [5:0] OffEtypeLo   = 6'd13;
  localparam logic [5:0] OffTci       = 6'd14;
  localparam logic [5:0] OffInner     = 6'd16;
  localparam logic [5:0] OffIp4Tagged = 6'd18;
  localparam logic [5:0] OffMax       = 6'd63;

  // Byte offsets relative to the start of the IPv4 header.
  localparam logic [5:0] RelTos       = 6'd1;
  localparam logic [5:0] RelTtl       = 6'd8;
  localparam logic [5:0] RelProto     = 6'd9;
  localparam logic [5:0] RelIpFirst   = 6'd12;
  localparam logic [5:0] RelIpLast    = 6'd19;
  localparam logic [5:0] RelSrcPortHi = 6'd20;
  localparam logic [5:0] RelSrcPortLo = 6'd21;
  localparam logic [5:0] RelDstPortHi = 6'd22;
  localparam logic [5:0] RelDstPortLo = 6'd23;

  localparam int unsigned KeyDataWidth = 256;

  typedef struct packed {
    logic [7:0]  port_out;
    logic [47:0] mac_dst;
    logic [47:0] mac_src;
    logic [15:0] outer_ethertype;
    logic [14:0] vlan_tag;
    logic [31:0] ipv4_src;
    logic [31:0] ipv4_dst;
    logic [7:0]  l3_protocol;
    logic [7:0]  ip_tos;
    logic [7:0]  ip_ttl;
    logic [15:0] l4_src_port;
    logic [15:0] l4_dst_port;
  } flow_key_t;

  // One incoming packet byte with its side information.
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       last;
    logic [7:0] port;
  } byte_in_t;

endpackage

// ===== hdl/packet_flow_key_extractor.sv =====
// Top level of the packet flow key extractor: byte stream in, flow key out.
// Depends on pfke_pkg, pfke_field_capture and packet_flow_key_extractor_defines.svh.
`include "packet_flow_key_extractor_defines.svh"

// Packet bytes enter one per cycle in wire order while the input is ready;
// the parse state advances on every accepted byte and the flow key of a packet
// is loaded into the output register by its last byte, so it appears on the
// master side in the cycle after that byte is accepted. The single output register
// sets the rate: bytes flow back to back while the sink takes keys, and the
// input stalls for as long as a key waits on a sink that holds tready low. Fields
// whose bytes never arrived read as zero; IPv4 fields are zero for non-IPv4
// frames, ports are zero unless the protocol is TCP or UDP.
module packet_flow_key_extractor (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // [7:0] data_byte
  input  logic         s_axis_tlast,   // last_byte
  input  logic [7:0]   s_axis_tuser,   // [7:0] ingress_port
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [7:0] port_out, [55:8] mac_dst, [103:56] mac_src, [119:104] outer_ethertype,
  // [134:120] vlan_tag, [166:135] ipv4_src, [198:167] ipv4_dst,
  // [206:199] l3_protocol, [214:207] ip_tos, [222:215] ip_ttl,
  // [238:223] l4_src_port, [254:239] l4_dst_port, [255] zero
  output logic [pfke_pkg::KeyDataWidth-1:0] m_axis_tdata
);
  import pfke_pkg::*;

  byte_in_t  byte_in;
  flow_key_t key_next;
  flow_key_t key_q;
  logic      out_valid_q, out_valid_d;
  logic      key_load;

  assign s_axis_tready = !out_valid_q || m_axis_tready;

  assign byte_in.valid = s_axis_tvalid && s_axis_tready;
  assign byte_in.data  = s_axis_tdata;
  assign byte_in.last  = s_axis_tlast;
  assign byte_in.port  = s_axis_tuser;

  pfke_field_capture u_capture (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .byte_i (byte_in),
    .key_o  (key_next)
  );

  assign key_load = byte_in.valid && s_axis_tlast;

  always_comb begin
    if (key_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (key_load) begin
      key_q <= key_next;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0,
                          key_q.l4_dst_port,
                          key_q.l4_src_port,
                          key_q.ip_ttl,
                          key_q.ip_tos,
                          key_q.l3_protocol,
                          key_q.ipv4_dst,
                          key_q.ipv4_src,
                          key_q.vlan_tag,
                          key_q.outer_ethertype,
                          key_q.mac_src,
                          key_q.mac_dst,
                          key_q.port_out};

  `PFKE_ASSERT_NEXT(a_key_from_last, clk_i, rst_ni,
                    !out_valid_q && !(s_axis_tvalid && s_axis_tlast), !out_valid_q,
                    "key shown without a last byte")
  `PFKE_ASSERT(a_vlan_only_tagged, clk_i, rst_ni,
               !out_valid_q || (key_q.outer_ethertype == EthTypeTag) ||
               (key_q.vlan_tag == '0),
               "VLAN tag set on untagged frame")
  `PFKE_ASSERT(a_proto_only_ip, clk_i, rst_ni,
               !out_valid_q || (key_q.l3_protocol == '0) ||
               (key_q.outer_ethertype == EthTypeIp4) ||
               (key_q.outer_ethertype == EthTypeTag),
               "protocol set on non-IP frame")

endmodule

// ===== hdl/pfke_field_capture.sv =====
// Per-packet header parse state and field capture of the flow key extractor.
// Depends on pfke_pkg and packet_flow_key_extractor_defines.svh.
`include "packet_flow_key_extractor_defines.svh"

module pfke_field_capture (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pfke_pkg::byte_in_t  byte_i,
  output pfke_pkg::flow_key_t key_o
);
  import pfke_pkg::*;

  logic [5:0]  off_q, off_d, off_u;
  logic        tag_q, tag_d, tag_u;
  logic [15:0] inner_q, inner_d, inner_u;
  logic [47:0] mac_dst_q, mac_dst_d, mac_dst_u;
  logic [47:0] mac_src_q, mac_src_d, mac_src_u;
  logic [15:0] et_q, et_d, et_u;
  logic [15:0] tci_q, tci_d, tci_u;
  logic [63:0] ip_q, ip_d, ip_u;
  logic [7:0]  proto_q, proto_d, proto_u;
  logic [7:0]  tos_q, tos_d, tos_u;
  logic [7:0]  ttl_q, ttl_d, ttl_u;
  logic [15:0] sp_q, sp_d, sp_u;
  logic [15:0] dp_q, dp_d, dp_u;

  logic [5:0]  base;
  logic [5:0]  rel;
  logic        is_ip4;
  logic        is_l4;
  logic [15:0] et_shift;
  logic [2:0]  pcp;

  always_comb begin
    off_u     = off_q;
    tag_u     = tag_q;
    inner_u   = inner_q;
    mac_dst_u = mac_dst_q;
    mac_src_u = mac_src_q;
    et_u      = et_q;
    tci_u     = tci_q;
    ip_u      = ip_q;
    proto_u   = proto_q;
    tos_u     = tos_q;
    ttl_u     = ttl_q;
    sp_u      = sp_q;
    dp_u      = dp_q;

    base     = tag_q ? OffIp4Tagged : OffTci;
    rel      = off_q - base;
    is_ip4   = tag_q ? (inner_q == EthTypeIp4) : (et_q == EthTypeIp4);
    is_l4    = (proto_q == IpProtoTcp) || (proto_q == IpProtoUdp);
    et_shift = {et_q[7:0], byte_i.data};

    if (off_q < OffMacSrc) begin
      mac_dst_u = {mac_dst_q[39:0], byte_i.data};
    end else if (off_q < OffEtype) begin
      mac_src_u = {mac_src_q[39:0], byte_i.data};
    end else if (off_q < OffTci) begin
      et_u = et_shift;
      if (off_q == OffEtypeLo) begin
        tag_u = (et_shift == EthTypeTag);
      end
    end else if (tag_q && (off_q < OffInner)) begin
      tci_u = {tci_q[7:0], byte_i.data};
    end else if (tag_q && (off_q < OffIp4Tagged)) begin
      inner_u = {inner_q[7:0], byte_i.data};
    end else if (is_ip4 && (off_q >= base)) begin
      priority if (rel == RelTos) begin
        tos_u = byte_i.data;
      end else if (rel == RelTtl) begin
        ttl_u = byte_i.data;
      end else if (rel == RelProto) begin
        proto_u = byte_i.data;
      end else if ((rel >= RelIpFirst) && (rel <= RelIpLast)) begin
        ip_u = {ip_q[55:0], byte_i.data};
      end else if (is_l4 && (rel == RelSrcPortHi)) begin
        sp_u[15:8] = byte_i.data;
      end else if (is_l4 && (rel == RelSrcPortLo)) begin
        sp_u[7:0] = byte_i.data;
      end else if (is_l4 && (rel == RelDstPortHi)) begin
        dp_u[15:8] = byte_i.data;
      end else if (is_l4 && (rel == RelDstPortLo)) begin
        dp_u[7:0] = byte_i.data;
      end else begin
        tos_u = tos_q;
      end
    end

    // Hold the offset once it reaches the top.
    off_u = (off_q == OffMax) ? off_q : off_q + 6'd1;
  end

  // Clear everything after the last byte so the next packet starts fresh.
  always_comb begin
    if (byte_i.last) begin
      off_d     = '0;
      tag_d     = 1'b0;
      inner_d   = '0;
      mac_dst_d = '0;
      mac_src_d = '0;
      et_d      = '0;
      tci_d     = '0;
      ip_d      = '0;
      proto_d   = '0;
      tos_d     = '0;
      ttl_d     = '0;
      sp_d      = '0;
      dp_d      = '0;
    end else begin
      off_d     = off_u;
      tag_d     = tag_u;
      inner_d   = inner_u;
      mac_dst_d = mac_dst_u;
      mac_src_d = mac_src_u;
      et_d      = et_u;
      tci_d     = tci_u;
      ip_d      = ip_u;
      proto_d   = proto_u;
      tos_d     = tos_u;
      ttl_d     = ttl_u;
      sp_d      = sp_u;
      dp_d      = dp_u;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q     <= '0;
      tag_q     <= 1'b0;
      inner_q   <= '0;
      mac_dst_q <= '0;
      mac_src_q <= '0;
      et_q      <= '0;
      tci_q     <= '0;
      ip_q      <= '0;
      proto_q   <= '0;
      tos_q     <= '0;
      ttl_q     <= '0;
      sp_q      <= '0;
      dp_q      <= '0;
    end else if (byte_i.valid) begin
      off_q     <= off_d;
      tag_q     <= tag_d;
      inner_q   <= inner_d;
      mac_dst_q <= mac_dst_d;
      mac_src_q <= mac_src_d;
      et_q      <= et_d;
      tci_q     <= tci_d;
      ip_q      <= ip_d;
      proto_q   <= proto_d;
      tos_q     <= tos_d;
      ttl_q     <= ttl_d;
      sp_q      <= sp_d;
      dp_q      <= dp_d;
    end
  end

  // Drop the DEI bit: priority goes above the VLAN id.
  assign pcp = 3'(tci_u >> PcpShift);

  always_comb begin
    key_o.port_out        = byte_i.port;
    key_o.mac_dst         = mac_dst_u;
    key_o.mac_src         = mac_src_u;
    key_o.outer_ethertype = et_u;
    key_o.vlan_tag        = tag_u ? {pcp, tci_u[11:0] & VidMask} : 15'd0;
    key_o.ipv4_src        = ip_u[63:32];
    key_o.ipv4_dst        = ip_u[31:0];
    key_o.l3_protocol     = proto_u;
    key_o.ip_tos          = tos_u;
    key_o.ip_ttl          = ttl_u;
    key_o.l4_src_port     = sp_u;
    key_o.l4_dst_port     = dp_u;
  end

  `PFKE_ASSERT_NEXT(a_off_saturate, clk_i, rst_ni,
                    byte_i.valid && !byte_i.last && (off_q == OffMax), off_q == OffMax,
                    "byte offset left saturation")
  `PFKE_ASSERT_NEXT(a_off_restart, clk_i, rst_ni,
                    byte_i.valid && byte_i.last, (off_q == '0) && !tag_q,
                    "state not cleared after last byte")
  `PFKE_ASSERT(a_tag_after_etype, clk_i, rst_ni,
               !tag_q || (off_q >= OffTci),
               "tag flag set before EtherType complete")
  `PFKE_ASSERT(a_ports_need_l4, clk_i, rst_ni,
               ((sp_q == '0) && (dp_q == '0)) || (proto_q == IpProtoTcp) ||
               (proto_q == IpProtoUdp),
               "ports captured without TCP or UDP")

endmodule

// ===== bench/packet_flow_key_extractor_checker.sv =====
// Flow key checker: watches the byte and key streams, predicts each key, compares.
// Depends on pfke_pkg for the key type and the header offsets and codes.
module packet_flow_key_extractor_checker (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_tvalid_i,
  input  logic         s_tready_i,
  input  logic [7:0]   s_tdata_i,
  input  logic         s_tlast_i,
  input  logic [7:0]   s_tuser_i,
  input  logic         m_tvalid_i,
  input  logic         m_tready_i,
  input  logic [255:0] m_tdata_i,
  output int           fail_count_o,
  output int           pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import pfke_pkg::*;

  flow_key_t expected_keys[$];
  int mismatches = 0;

  // Parse state of the packet in flight.
  logic [5:0]  hdr_offset;
  logic        tag_flag;
  logic [15:0] inner_type;
  logic [47:0] acc_mac_dst;
  logic [47:0] acc_mac_src;
  logic [15:0] acc_etype;
  logic [15:0] acc_tci;
  logic [63:0] acc_ip_pair;
  logic [7:0]  acc_tos;
  logic [7:0]  acc_ttl;
  logic [7:0]  acc_proto;
  logic [15:0] acc_sport;
  logic [15:0] acc_dport;

  task automatic clear_key();
    hdr_offset  = '0;
    tag_flag    = 1'b0;
    inner_type  = '0;
    acc_mac_dst = '0;
    acc_mac_src = '0;
    acc_etype   = '0;
    acc_tci     = '0;
    acc_ip_pair = '0;
    acc_tos     = '0;
    acc_ttl     = '0;
    acc_proto   = '0;
    acc_sport   = '0;
    acc_dport   = '0;
  endtask

  task automatic parse_byte(input logic [7:0] b, input logic last, input logic [7:0] port);
    logic [5:0] ip_base;
    logic       is_ip4;
    logic [5:0] rel;
    flow_key_t  k;
    // Untagged frames start the IPv4 header where the tag would sit.
    ip_base = tag_flag ? OffIp4Tagged : OffTci;
    is_ip4  = tag_flag ? (inner_type == EthTypeIp4) : (acc_etype == EthTypeIp4);
    rel     = hdr_offset - ip_base;
    if (hdr_offset < OffMacSrc) begin
      acc_mac_dst = {acc_mac_dst[39:0], b};
    end else if (hdr_offset < OffEtype) begin
      acc_mac_src = {acc_mac_src[39:0], b};
    end else if (hdr_offset <= OffEtypeLo) begin
      acc_etype = {acc_etype[7:0], b};
      if (hdr_offset == OffEtypeLo) tag_flag = (acc_etype == EthTypeTag);
    end else if (tag_flag && hdr_offset < OffInner) begin
      acc_tci = {acc_tci[7:0], b};
    end else if (tag_flag && hdr_offset < OffIp4Tagged) begin
      inner_type = {inner_type[7:0], b};
    end else if (is_ip4) begin
      if (rel == RelTos) begin
        acc_tos = b;
      end else if (rel == RelTtl) begin
        acc_ttl = b;
      end else if (rel == RelProto) begin
        acc_proto = b;
      end else if (rel >= RelIpFirst && rel <= RelIpLast) begin
        acc_ip_pair = {acc_ip_pair[55:0], b};
      end else if (acc_proto == IpProtoTcp || acc_proto == IpProtoUdp) begin
        case (rel)
          RelSrcPortHi: acc_sport[15:8] = b;
          RelSrcPortLo: acc_sport[7:0]  = b;
          RelDstPortHi: acc_dport[15:8] = b;
          RelDstPortLo: acc_dport[7:0]  = b;
          default: ;
        endcase
      end
    end
    if (hdr_offset != OffMax) hdr_offset = hdr_offset + 6'd1;
    if (last) begin
      k.port_out        = port;
      k.mac_dst         = acc_mac_dst;
      k.mac_src         = acc_mac_src;
      k.outer_ethertype = acc_etype;
      // Drop the DEI bit between priority and VLAN id.
      k.vlan_tag        = tag_flag ? {acc_tci[15:PcpShift], acc_tci[11:0] & VidMask} : '0;
      k.ipv4_src        = acc_ip_pair[63:32];
      k.ipv4_dst        = acc_ip_pair[31:0];
      k.l3_protocol     = acc_proto;
      k.ip_tos          = acc_tos;
      k.ip_ttl          = acc_ttl;
      k.l4_src_port     = acc_sport;
      k.l4_dst_port     = acc_dport;
      expected_keys.push_back(k);
      clear_key();
    end
  endtask

  task automatic compare_field(input string name, input logic [47:0] want,
                               input logic [47:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h actual %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  task automatic check_key(input logic [255:0] d);
    flow_key_t want;
    if (expected_keys.size() == 0) begin
      $display("%0t: flow key expected none actual %h", $time, d);
      mismatches++;
    end else begin
      want = expected_keys.pop_front();
      compare_field("port_out", 48'(want.port_out), 48'(d[7:0]));
      compare_field("mac_dst", want.mac_dst, d[55:8]);
      compare_field("mac_src", want.mac_src, d[103:56]);
      compare_field("outer_ethertype", 48'(want.outer_ethertype), 48'(d[119:104]));
      compare_field("vlan_tag", 48'(want.vlan_tag), 48'(d[134:120]));
      compare_field("ipv4_src", 48'(want.ipv4_src), 48'(d[166:135]));
      compare_field("ipv4_dst", 48'(want.ipv4_dst), 48'(d[198:167]));
      compare_field("l3_protocol", 48'(want.l3_protocol), 48'(d[206:199]));
      compare_field("ip_tos", 48'(want.ip_tos), 48'(d[214:207]));
      compare_field("ip_ttl", 48'(want.ip_ttl), 48'(d[222:215]));
      compare_field("l4_src_port", 48'(want.l4_src_port), 48'(d[238:223]));
      compare_field("l4_dst_port", 48'(want.l4_dst_port), 48'(d[254:239]));
    end
  endtask

  // Check the key side first: a key never leaves on the edge its last byte enters.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      clear_key();
    end else begin
      if (m_tvalid_i && m_tready_i) check_key(m_tdata_i);
      if (s_tvalid_i && s_tready_i) parse_byte(s_tdata_i, s_tlast_i, s_tuser_i);
    end
    fail_count_o <= mismatches;
    pending_o    <= expected_keys.size();
  end

endmodule

// ===== bench/packet_flow_key_extractor_tb.sv =====
// Testbench top of the packet flow key extractor: clock, reset, frame stimulus, verdict.
// Depends on pfke_pkg, the extractor RTL and packet_flow_key_extractor_checker.
module packet_flow_key_extractor_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pfke_pkg::*;

  localparam logic [15:0] EthTypeArp  = 16'h0806;
  localparam logic [15:0] EthTypeIp6  = 16'h86DD;
  localparam logic [7:0]  IpProtoIcmp = 8'd1;

  typedef enum int {FillRandom, FillOnes, FillZeros} fill_e;
  typedef enum int {IdleNone, IdleSender, IdleReceiver, IdleBoth} idle_e;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata = '0;
  logic         s_axis_tlast = 1'b0;
  logic [7:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [255:0] m_axis_tdata;
  int           fail_count;
  int           pending_keys;

  int gap_pct = 0;
  int stall_pct = 0;
  int bytes_sent = 0;
  int frames_sent = 0;
  logic [7:0] frame_bytes[$];

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  packet_flow_key_extractor dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  packet_flow_key_extractor_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_axis_tvalid),
    .s_tready_i   (s_axis_tready),
    .s_tdata_i    (s_axis_tdata),
    .s_tlast_i    (s_axis_tlast),
    .s_tuser_i    (s_axis_tuser),
    .m_tvalid_i   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .m_tdata_i    (m_axis_tdata),
    .fail_count_o (fail_count),
    .pending_o    (pending_keys)
  );

  always @(posedge clk_i) m_axis_tready <= ($urandom_range(99) >= stall_pct);

  initial begin
    #3ms;
    $display("CHECK FAILED");
    $finish;
  end

  task automatic set_idle(input idle_e mode);
    case (mode)
      IdleNone:     begin gap_pct = 0;  stall_pct = 0;  end
      IdleSender:   begin gap_pct = 82; stall_pct = 0;  end
      IdleReceiver: begin gap_pct = 0;  stall_pct = 82; end
      default:      begin gap_pct = 6;  stall_pct = 6;  end
    endcase
  endtask

  function automatic logic [7:0] fill_byte(input fill_e fill);
    case (fill)
      FillOnes:  return 8'hFF;
      FillZeros: return 8'h00;
      default:   return 8'($urandom_range(255));
    endcase
  endfunction

  // Assemble MACs, optional tag, EtherType, IPv4 header and ports for IPv4, then payload.
  task automatic build_frame(input bit with_tag, input logic [15:0] l3_type,
                             input logic [7:0] proto, input int tail_len, input fill_e fill);
    frame_bytes.delete();
    repeat (12) frame_bytes.push_back(fill_byte(fill));
    if (with_tag) begin
      frame_bytes.push_back(EthTypeTag[15:8]);
      frame_bytes.push_back(EthTypeTag[7:0]);
      repeat (2) frame_bytes.push_back(fill_byte(fill));
    end
    frame_bytes.push_back(l3_type[15:8]);
    frame_bytes.push_back(l3_type[7:0]);
    if (l3_type == EthTypeIp4) begin
      for (int i = 0; i < 20; i++) begin
        frame_bytes.push_back((i == int'(RelProto)) ? proto : fill_byte(fill));
      end
      repeat (4) frame_bytes.push_back(fill_byte(fill));
    end
    repeat (tail_len) frame_bytes.push_back(fill_byte(fill));
  endtask

  task automatic truncate_frame(input int keep);
    while (frame_bytes.size() > keep) void'(frame_bytes.pop_back());
  endtask

  task automatic send_byte(input logic [7:0] b, input logic last, input logic [7:0] port);
    while ($urandom_range(99) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    s_axis_tuser  <= port;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    bytes_sent++;
  endtask

  task automatic send_frame(input logic [7:0] port);
    for (int i = 0; i < frame_bytes.size(); i++) begin
      send_byte(frame_bytes[i], i == frame_bytes.size() - 1, port);
    end
    frames_sent++;
  endtask

  // Hold the sender until every outstanding key has been taken.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_keys != 0) @(posedge clk_i);
  endtask

  task automatic send_random_frame();
    int          kind;
    int          pick;
    bit          with_tag;
    logic [15:0] l3_type;
    logic [7:0]  proto;
    int          tail_len;
    kind     = $urandom_range(99);
    with_tag = ($urandom_range(99) < 40);
    pick     = $urandom_range(99);
    if (pick < 75) l3_type = EthTypeIp4;
    else if (pick < 85) l3_type = EthTypeArp;
    else if (pick < 92) l3_type = EthTypeIp6;
    else l3_type = 16'($urandom_range(16'hFFFF));
    pick = $urandom_range(99);
    if (pick < 40) proto = IpProtoTcp;
    else if (pick < 80) proto = IpProtoUdp;
    else proto = 8'($urandom_range(255));
    tail_len = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(12);
    build_frame(with_tag, l3_type, proto, tail_len, FillRandom);
    if (kind < 15) begin
      truncate_frame($urandom_range(1, frame_bytes.size()));
    end else if (kind < 25) begin
      // Noise: no header structure at all.
      frame_bytes.delete();
      repeat ($urandom_range(1, 60)) frame_bytes.push_back(8'($urandom_range(255)));
    end
    send_frame(8'($urandom_range(255)));
  endtask

  initial begin
    idle_e mode;
    idle_e next_mode;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    set_idle(IdleNone);

    // Field extremes, tag handling with DEI set, non-IPv4, other protocol.
    build_frame(1'b0, EthTypeIp4, IpProtoTcp, 0, FillOnes);
    send_frame(8'hFF);
    build_frame(1'b1, EthTypeIp4, IpProtoUdp, 0, FillZeros);
    send_frame(8'h00);
    build_frame(1'b1, EthTypeIp4, IpProtoUdp, 3, FillOnes);
    send_frame(8'hA5);
    build_frame(1'b1, EthTypeIp6, IpProtoTcp, 10, FillRandom);
    send_frame(8'h5A);
    build_frame(1'b0, EthTypeArp, IpProtoTcp, 30, FillRandom);
    send_frame(8'h01);
    build_frame(1'b0, EthTypeIp4, IpProtoIcmp, 2, FillRandom);
    send_frame(8'h80);
    // Long frame: offset saturates well before the end.
    build_frame(1'b0, EthTypeIp4, IpProtoTcp, 40, FillRandom);
    send_frame(8'h7F);
    // Short frames: single bytes and cuts inside the headers.
    frame_bytes = '{8'hFF};
    send_frame(8'hFF);
    frame_bytes = '{8'h00};
    send_frame(8'h00);
    build_frame(1'b0, EthTypeIp4, IpProtoTcp, 0, FillRandom);
    truncate_frame(16);
    send_frame(8'h33);
    build_frame(1'b0, EthTypeIp4, IpProtoUdp, 0, FillRandom);
    truncate_frame(30);
    send_frame(8'hCC);
    build_frame(1'b1, EthTypeIp4, IpProtoTcp, 0, FillRandom);
    truncate_frame(15);
    send_frame(8'h0F);
    wait_drained();

    // Rotate through the idle phases every hundred bytes or so.
    mode = IdleNone;
    while (bytes_sent < 800) begin
      next_mode = idle_e'((bytes_sent / 100) % 4);
      if (next_mode != mode) begin
        wait_drained();
        mode = next_mode;
        set_idle(mode);
      end
      send_random_frame();
    end

    // Let the sink take everything, then watch for stray keys.
    set_idle(IdleNone);
    wait_drained();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0 && pending_keys == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/pfke_pkg.sv
hdl/pfke_field_capture.sv
hdl/packet_flow_key_extractor.sv
bench/packet_flow_key_extractor_checker.sv
bench/packet_flow_key_extractor_tb.sv
